### rtl/ucms_pkg.sv
// ----------------------------------------------------------------------------
// ucms_pkg
// Shared types, constants and helpers for the drive-command sequencer: the
// command codes, item kinds, register indexes, reset values and the structs
// that pass between the queue, the drive control and the top level.
// ----------------------------------------------------------------------------
package ucms_pkg;

    // Default depth of the command ring.
    localparam int QueueSlotsDefault = 10;

    // Field widths.
    localparam int FuncW    = 2;
    localparam int ByteW    = 8;
    localparam int LevelW   = 12;
    localparam int TurnW    = 16;
    localparam int DutyW    = 10;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Item kinds.
    localparam logic [FuncW-1:0] FUNC_BYTE = 2'd0;
    localparam logic [FuncW-1:0] FUNC_LOOP = 2'd1;
    localparam logic [FuncW-1:0] FUNC_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_OBST_THR  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FIRE_THR  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TURN_DUR  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CRUISE    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TURN_SLOW = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TURN_FAST = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_REVERSE   = 3'd6;

    // Register reset values.
    localparam logic [LevelW-1:0] RST_OBST_THR  = 12'd300;
    localparam logic [LevelW-1:0] RST_FIRE_THR  = 12'd300;
    localparam logic [TurnW-1:0]  RST_TURN_DUR  = 16'd1000;
    localparam logic [DutyW-1:0]  RST_CRUISE    = 10'd500;
    localparam logic [DutyW-1:0]  RST_TURN_SLOW = 10'd200;
    localparam logic [DutyW-1:0]  RST_TURN_FAST = 10'd800;
    localparam logic [DutyW-1:0]  RST_REVERSE   = 10'd500;

    // Motor duty limits and reset duties.
    localparam logic [DutyW-1:0] DUTY_MAX      = 10'd999;
    localparam logic [DutyW-1:0] RST_FWD_DUTY  = 10'd500;
    localparam logic [DutyW-1:0] RST_REV_DUTY  = 10'd0;

    // Received characters that carry a drive command.
    localparam logic [ByteW-1:0] CHAR_STRAIGHT = 8'h73; // 's'
    localparam logic [ByteW-1:0] CHAR_LEFT     = 8'h6C; // 'l'
    localparam logic [ByteW-1:0] CHAR_RIGHT    = 8'h72; // 'r'
    localparam logic [ByteW-1:0] CHAR_BACK     = 8'h62; // 'b'
    localparam logic [ByteW-1:0] CHAR_STOP     = 8'h71; // 'q'

    // Drive command codes as held in the ring.
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_STRAIGHT = 3'd1,
        CMD_LEFT     = 3'd2,
        CMD_RIGHT    = 3'd3,
        CMD_BACK     = 3'd4,
        CMD_STOP     = 3'd5
    } cmd_t;

    // One input item.
    typedef struct packed {
        logic [FuncW-1:0]  func;
        logic [ByteW-1:0]  rx_byte;
        logic [LevelW-1:0] obstacle_level;
        logic [LevelW-1:0] fire_level;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [DutyW-1:0] left_fwd;
        logic [DutyW-1:0] left_rev;
        logic [DutyW-1:0] right_fwd;
        logic [DutyW-1:0] right_rev;
        logic             obstacle_alert;
        logic             fire_alert;
        logic             turning;
    } result_t;

    // Configuration register set.
    typedef struct packed {
        logic [LevelW-1:0] obst_thr;
        logic [LevelW-1:0] fire_thr;
        logic [TurnW-1:0]  turn_dur;
        logic [DutyW-1:0]  cruise;
        logic [DutyW-1:0]  turn_slow;
        logic [DutyW-1:0]  turn_fast;
        logic [DutyW-1:0]  reverse;
    } cfg_t;

    // Requests from the drive control to the command ring.
    typedef struct packed {
        logic push;
        cmd_t push_cmd;
        logic pop;
        logic flush;
    } queue_req_t;

    // Status of the command ring.
    typedef struct packed {
        logic empty;
        logic full;
        cmd_t front;
    } queue_stat_t;

    // Clamp a duty to the largest legal value.
    function automatic logic [DutyW-1:0] sat_duty(input logic [DutyW-1:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

endpackage

### rtl/ucms_cmd_queue.sv
// ----------------------------------------------------------------------------
// ucms_cmd_queue
// Ring of drive commands with one write port and one registered read port.
// The read port always prefetches the entry after the head, so the oldest
// command is ready for the next item without a combinational memory read.
// ----------------------------------------------------------------------------
module ucms_cmd_queue #(
    parameter int QueueSlots = ucms_pkg::QueueSlotsDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ucms_pkg::queue_req_t  req,
    output ucms_pkg::queue_stat_t stat
);

    localparam int PtrW = $clog2(QueueSlots);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(QueueSlots - 1);

    logic [PtrW-1:0] head_reg, head_next;
    logic [PtrW-1:0] tail_reg, tail_next;
    logic [PtrW-1:0] wr_addr;
    logic [PtrW-1:0] rd_addr;
    ucms_pkg::cmd_t  slot_mem [QueueSlots];
    ucms_pkg::cmd_t  rd_data_reg;

    // Advance a ring index, wrapping after the last slot.
    function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] i);
        return (i == LastIdx) ? '0 : i + PtrW'(1);
    endfunction

    // Pointer update. A flush empties the ring; a pop steps the head; a push steps the tail.
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        wr_addr   = ring_next(tail_reg);
        if (req.flush) begin
            head_next = tail_reg;
        end else if (req.pop) begin
            head_next = ring_next(head_reg);
        end
        if (req.push) begin
            tail_next = wr_addr;
        end
        rd_addr = ring_next(head_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Command storage, with the write forwarded when it hits the prefetch.
    always_ff @(posedge aclk) begin
        if (req.push) begin
            slot_mem[wr_addr] <= req.push_cmd;
        end
        if (req.push && (wr_addr == rd_addr)) begin
            rd_data_reg <= req.push_cmd;
        end else begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Ring status.
    assign stat.empty = (head_reg == tail_reg);
    assign stat.full  = (ring_next(tail_reg) == head_reg);
    assign stat.front = rd_data_reg;

`ifndef NO_ASSERTIONS
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= LastIdx) && (tail_reg <= LastIdx))
        else $error("Ring pointer beyond the last slot.");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        req.flush |=> (head_reg == tail_reg))
        else $error("Ring not empty after a flush.");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        req.push |-> !stat.full)
        else $error("Command pushed into a full ring.");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.pop |-> !stat.empty)
        else $error("Command popped from an empty ring.");
`endif

endmodule

### rtl/ucms_drive_ctrl.sv
// ----------------------------------------------------------------------------
// ucms_drive_ctrl
// Decodes one item, issues ring requests, runs the chosen command on the
// four motor duties and keeps the turn timer. Produces the result of the item.
// ----------------------------------------------------------------------------
module ucms_drive_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  ucms_pkg::item_t       item,
    input  ucms_pkg::cfg_t        cfg,
    input  ucms_pkg::queue_stat_t stat,
    output ucms_pkg::queue_req_t  req,
    output ucms_pkg::result_t     result
);

    logic [ucms_pkg::DutyW-1:0] lf_reg, lf_next;
    logic [ucms_pkg::DutyW-1:0] lr_reg, lr_next;
    logic [ucms_pkg::DutyW-1:0] rf_reg, rf_next;
    logic [ucms_pkg::DutyW-1:0] rr_reg, rr_next;
    logic [ucms_pkg::TurnW-1:0] turn_reg, turn_next;
    ucms_pkg::cmd_t             byte_cmd;
    ucms_pkg::cmd_t             run_cmd;
    logic                       obst_hit;
    logic                       fire_hit;

    // Map a received character onto a command.
    always_comb begin
        unique case (item.rx_byte)
            ucms_pkg::CHAR_STRAIGHT: byte_cmd = ucms_pkg::CMD_STRAIGHT;
            ucms_pkg::CHAR_LEFT:     byte_cmd = ucms_pkg::CMD_LEFT;
            ucms_pkg::CHAR_RIGHT:    byte_cmd = ucms_pkg::CMD_RIGHT;
            ucms_pkg::CHAR_BACK:     byte_cmd = ucms_pkg::CMD_BACK;
            ucms_pkg::CHAR_STOP:     byte_cmd = ucms_pkg::CMD_STOP;
            default:                 byte_cmd = ucms_pkg::CMD_NONE;
        endcase
    end

    // Item handling: ring requests, command execution and timer update.
    always_comb begin
        lf_next      = lf_reg;
        lr_next      = lr_reg;
        rf_next      = rf_reg;
        rr_next      = rr_reg;
        turn_next    = turn_reg;
        req.push     = 1'b0;
        req.push_cmd = byte_cmd;
        req.pop      = 1'b0;
        req.flush    = 1'b0;
        run_cmd      = ucms_pkg::CMD_NONE;
        obst_hit     = 1'b0;
        fire_hit     = 1'b0;
        if (go) begin
            case (item.func)
                ucms_pkg::FUNC_BYTE: begin
                    req.push = (byte_cmd != ucms_pkg::CMD_NONE) && !stat.full;
                end
                ucms_pkg::FUNC_LOOP: begin
                    if (turn_reg == '0) begin
                        obst_hit = item.obstacle_level > cfg.obst_thr;
                        fire_hit = item.fire_level > cfg.fire_thr;
                        // A sensor stop clears the ring and runs a stop at once.
                        if (obst_hit || fire_hit) begin
                            req.flush = 1'b1;
                            run_cmd   = ucms_pkg::CMD_STOP;
                        end else if (!stat.empty) begin
                            req.pop = 1'b1;
                            run_cmd = stat.front;
                        end
                    end
                end
                ucms_pkg::FUNC_TICK: begin
                    if (turn_reg != '0) begin
                        turn_next = turn_reg - ucms_pkg::TurnW'(1);
                    end
                end
                default: begin
                end
            endcase

            case (run_cmd)
                ucms_pkg::CMD_STRAIGHT: begin
                    lf_next = ucms_pkg::sat_duty(cfg.cruise);
                    lr_next = '0;
                    rf_next = ucms_pkg::sat_duty(cfg.cruise);
                    rr_next = '0;
                end
                ucms_pkg::CMD_LEFT: begin
                    lf_next   = ucms_pkg::sat_duty(cfg.turn_slow);
                    lr_next   = '0;
                    rf_next   = ucms_pkg::sat_duty(cfg.turn_fast);
                    rr_next   = '0;
                    turn_next = cfg.turn_dur;
                end
                ucms_pkg::CMD_RIGHT: begin
                    lf_next   = ucms_pkg::sat_duty(cfg.turn_fast);
                    lr_next   = '0;
                    rf_next   = ucms_pkg::sat_duty(cfg.turn_slow);
                    rr_next   = '0;
                    turn_next = cfg.turn_dur;
                end
                ucms_pkg::CMD_BACK: begin
                    lf_next = '0;
                    lr_next = ucms_pkg::sat_duty(cfg.reverse);
                    rf_next = '0;
                    rr_next = ucms_pkg::sat_duty(cfg.reverse);
                end
                ucms_pkg::CMD_STOP: begin
                    lf_next = '0;
                    lr_next = '0;
                    rf_next = '0;
                    rr_next = '0;
                end
                default: begin
                end
            endcase

            // A turn that has just run out, or one of zero length, stops both motors.
            if ((turn_reg != '0 || run_cmd == ucms_pkg::CMD_LEFT
                    || run_cmd == ucms_pkg::CMD_RIGHT) && turn_next == '0) begin
                lf_next = '0;
                lr_next = '0;
                rf_next = '0;
                rr_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lf_reg   <= ucms_pkg::RST_FWD_DUTY;
            lr_reg   <= ucms_pkg::RST_REV_DUTY;
            rf_reg   <= ucms_pkg::RST_FWD_DUTY;
            rr_reg   <= ucms_pkg::RST_REV_DUTY;
            turn_reg <= '0;
        end else begin
            lf_reg   <= lf_next;
            lr_reg   <= lr_next;
            rf_reg   <= rf_next;
            rr_reg   <= rr_next;
            turn_reg <= turn_next;
        end
    end

    // Result reflects the state after this item.
    assign result.left_fwd       = lf_next;
    assign result.left_rev       = lr_next;
    assign result.right_fwd      = rf_next;
    assign result.right_rev      = rr_next;
    assign result.obstacle_alert = obst_hit;
    assign result.fire_alert     = fire_hit;
    assign result.turning        = (turn_next != '0);

endmodule

### rtl/uart_command_motor_sequencer_unit.sv
// ----------------------------------------------------------------------------
// uart_command_motor_sequencer_unit
// Drive-command sequencer for a two-motor vehicle: queues serial commands,
// runs them on sensor-checked loop passes and times turns on millisecond ticks.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the result channel
// stalls, and returns exactly one result for each, via the input register
// and then the result register. Each item passes once through the decode
// and duty logic; the command ring is a register memory with one write
// port and one registered read port that prefetches the oldest command,
// so no item waits on it. Configuration writes take effect at once and
// should be made while the block holds no item.
module uart_command_motor_sequencer_unit #(
    parameter int QueueSlots = ucms_pkg::QueueSlotsDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port.
    input  logic                          cfg_we,
    input  logic [ucms_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ucms_pkg::CfgDataW-1:0] cfg_wdata,
    // Input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ucms_pkg::FuncW-1:0]    s_func,
    input  logic [ucms_pkg::ByteW-1:0]    s_rx_byte,
    input  logic [ucms_pkg::LevelW-1:0]   s_obstacle_level,
    input  logic [ucms_pkg::LevelW-1:0]   s_fire_level,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ucms_pkg::DutyW-1:0]    m_out_left_fwd,
    output logic [ucms_pkg::DutyW-1:0]    m_out_left_rev,
    output logic [ucms_pkg::DutyW-1:0]    m_out_right_fwd,
    output logic [ucms_pkg::DutyW-1:0]    m_out_right_rev,
    output logic                          m_obstacle_alert,
    output logic                          m_fire_alert,
    output logic                          m_turning
);

    ucms_pkg::cfg_t        cfg_reg;
    ucms_pkg::item_t       in_item_reg;
    logic                  in_valid_reg;
    ucms_pkg::result_t     res_reg;
    ucms_pkg::result_t     res_next;
    logic                  m_valid_reg;
    logic                  advance;
    logic                  go;
    ucms_pkg::queue_req_t  q_req;
    ucms_pkg::queue_stat_t q_stat;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.obst_thr  <= ucms_pkg::RST_OBST_THR;
            cfg_reg.fire_thr  <= ucms_pkg::RST_FIRE_THR;
            cfg_reg.turn_dur  <= ucms_pkg::RST_TURN_DUR;
            cfg_reg.cruise    <= ucms_pkg::RST_CRUISE;
            cfg_reg.turn_slow <= ucms_pkg::RST_TURN_SLOW;
            cfg_reg.turn_fast <= ucms_pkg::RST_TURN_FAST;
            cfg_reg.reverse   <= ucms_pkg::RST_REVERSE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ucms_pkg::REG_OBST_THR:  cfg_reg.obst_thr  <= cfg_wdata[ucms_pkg::LevelW-1:0];
                ucms_pkg::REG_FIRE_THR:  cfg_reg.fire_thr  <= cfg_wdata[ucms_pkg::LevelW-1:0];
                ucms_pkg::REG_TURN_DUR:  cfg_reg.turn_dur  <= cfg_wdata[ucms_pkg::TurnW-1:0];
                ucms_pkg::REG_CRUISE:    cfg_reg.cruise    <= cfg_wdata[ucms_pkg::DutyW-1:0];
                ucms_pkg::REG_TURN_SLOW: cfg_reg.turn_slow <= cfg_wdata[ucms_pkg::DutyW-1:0];
                ucms_pkg::REG_TURN_FAST: cfg_reg.turn_fast <= cfg_wdata[ucms_pkg::DutyW-1:0];
                ucms_pkg::REG_REVERSE:   cfg_reg.reverse   <= cfg_wdata[ucms_pkg::DutyW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: an item moves on whenever the result register is free or its result is being taken.
    assign advance = !m_valid_reg || m_ready;
    assign go      = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func           <= s_func;
            in_item_reg.rx_byte        <= s_rx_byte;
            in_item_reg.obstacle_level <= s_obstacle_level;
            in_item_reg.fire_level     <= s_fire_level;
        end
    end

    ucms_cmd_queue #(
        .QueueSlots (QueueSlots)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .stat    (q_stat)
    );

    ucms_drive_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .stat    (q_stat),
        .req     (q_req),
        .result  (res_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_left_fwd   = res_reg.left_fwd;
    assign m_out_left_rev   = res_reg.left_rev;
    assign m_out_right_fwd  = res_reg.right_fwd;
    assign m_out_right_rev  = res_reg.right_rev;
    assign m_obstacle_alert = res_reg.obstacle_alert;
    assign m_fire_alert     = res_reg.fire_alert;
    assign m_turning        = res_reg.turning;

endmodule
